[rtl/indexed_deque_core_defines.svh]
// ---------------------------------------------------------------------------
// Indexed deque assertion macros
// Shared forms for the concurrent checks on the deque core.
// ---------------------------------------------------------------------------
`ifndef INDEXED_DEQUE_CORE_DEFINES_SVH
`define INDEXED_DEQUE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IDQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("indexed deque check failed");

// The consequent must hold in the cycle after the antecedent.
`define IDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("indexed deque check failed");

`endif

[rtl/idq_pkg.sv]
// ---------------------------------------------------------------------------
// Indexed deque package
// Operation and status codes, controller states and shared types.
// ---------------------------------------------------------------------------
`default_nettype none

package idq_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned FUNC_W = 3;
  localparam int unsigned STAT_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH_FRONT = 3'd0,
    FUNC_PUSH_BACK  = 3'd1,
    FUNC_POP_FRONT  = 3'd2,
    FUNC_POP_BACK   = 3'd3,
    FUNC_READ       = 3'd4
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_RANGE = 2'd2,
    STATUS_FULL  = 2'd3
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_e;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

`default_nettype wire

[rtl/idq_mem.sv]
// ---------------------------------------------------------------------------
// Indexed deque element memory
// Single-port synchronous RAM with a registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module idq_mem #(
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned PtrW = $clog2(DEPTH)
) (
  input  wire logic                         clk_i,
  input  wire idq_pkg::mem_ctl_t            ctl_i,
  input  wire logic [PtrW-1:0]              addr_i,
  input  wire logic [idq_pkg::DATA_W-1:0]   wdata_i,
  output logic      [idq_pkg::DATA_W-1:0]   rdata_o
);

  logic [idq_pkg::DATA_W-1:0] mem_q [DEPTH];
  logic [idq_pkg::DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/idq_ctrl.sv]
// ---------------------------------------------------------------------------
// Indexed deque controller
// Front pointer and count, address generation and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module idq_ctrl #(
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned PtrW = $clog2(DEPTH),
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic        [idq_pkg::FUNC_W-1:0]   func_i,
  input  wire logic signed [idq_pkg::DATA_W-1:0]   data_in_i,
  input  wire logic        [PtrW-1:0]              position_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed      [idq_pkg::DATA_W-1:0]   data_out_o,
  output logic             [CntW-1:0]              occupancy_o,
  output logic             [idq_pkg::STAT_W-1:0]   status_o,
  output idq_pkg::mem_ctl_t                        mem_ctl_o,
  output logic             [PtrW-1:0]              mem_addr_o,
  output logic             [idq_pkg::DATA_W-1:0]   mem_wdata_o,
  input  wire logic        [idq_pkg::DATA_W-1:0]   mem_rdata_i
);

  localparam logic [PtrW:0]   DepthWrap = (PtrW + 1)'(DEPTH);
  localparam logic [PtrW-1:0] LastSlot  = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCount = CntW'(DEPTH);

  idq_pkg::state_e state_q, state_d;
  logic [PtrW-1:0] front_q, front_d;
  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q, out_valid_d;
  logic signed [idq_pkg::DATA_W-1:0] data_q;
  logic [CntW-1:0] occ_q;
  logic [idq_pkg::STAT_W-1:0] status_q;

  logic                       accept;
  logic                       read_op;
  logic                       wr_req;
  logic                       rd_req;
  idq_pkg::status_e           res_status;
  logic [PtrW-1:0]            ring_off;
  logic [PtrW:0]              ring_sum;
  logic [PtrW:0]              ring_wrap;
  logic [PtrW-1:0]            ring_addr;
  logic [PtrW-1:0]            front_dec;
  logic [PtrW-1:0]            front_inc;
  logic [CntW-1:0]            count_dec;
  logic [CntW-1:0]            count_inc;
  logic                       is_full;
  logic                       is_empty;
  logic [PtrW-1:0]            addr;

  assign is_full   = (count_q == FullCount);
  assign is_empty  = (count_q == '0);
  assign count_dec = count_q - CntW'(1);
  assign count_inc = count_q + CntW'(1);
  assign front_dec = (front_q == '0) ? LastSlot : front_q - PtrW'(1);
  assign front_inc = (front_q == LastSlot) ? '0 : front_q + PtrW'(1);

  always_comb begin
    case (func_i)
      idq_pkg::FUNC_PUSH_BACK: ring_off = count_q[PtrW-1:0];
      idq_pkg::FUNC_POP_BACK:  ring_off = count_dec[PtrW-1:0];
      idq_pkg::FUNC_READ:      ring_off = position_i;
      default:                 ring_off = '0;
    endcase
  end

  assign ring_sum  = {1'b0, front_q} + {1'b0, ring_off};
  assign ring_wrap = ring_sum - DepthWrap;
  assign ring_addr = (ring_sum >= DepthWrap) ? ring_wrap[PtrW-1:0] : ring_sum[PtrW-1:0];

  always_comb begin
    front_d    = front_q;
    count_d    = count_q;
    res_status = idq_pkg::STATUS_OK;
    wr_req     = 1'b0;
    rd_req     = 1'b0;
    read_op    = 1'b0;
    addr       = ring_addr;
    case (func_i)
      idq_pkg::FUNC_PUSH_FRONT: begin
        if (is_full) begin
          res_status = idq_pkg::STATUS_FULL;
        end else begin
          addr    = front_dec;
          wr_req  = 1'b1;
          front_d = front_dec;
          count_d = count_inc;
        end
      end
      idq_pkg::FUNC_PUSH_BACK: begin
        if (is_full) begin
          res_status = idq_pkg::STATUS_FULL;
        end else begin
          wr_req  = 1'b1;
          count_d = count_inc;
        end
      end
      idq_pkg::FUNC_POP_FRONT: begin
        if (is_empty) begin
          res_status = idq_pkg::STATUS_EMPTY;
        end else begin
          addr    = front_q;
          rd_req  = 1'b1;
          read_op = 1'b1;
          front_d = front_inc;
          count_d = count_dec;
        end
      end
      idq_pkg::FUNC_POP_BACK: begin
        if (is_empty) begin
          res_status = idq_pkg::STATUS_EMPTY;
        end else begin
          rd_req  = 1'b1;
          read_op = 1'b1;
          count_d = count_dec;
        end
      end
      idq_pkg::FUNC_READ: begin
        if (CntW'(position_i) >= count_q) begin
          res_status = idq_pkg::STATUS_RANGE;
        end else begin
          rd_req  = 1'b1;
          read_op = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      idq_pkg::ST_IDLE: begin
        in_ready_o = !out_valid_q || out_ready_i;
        if (in_valid_i && in_ready_o) begin
          if (read_op) begin
            state_d = idq_pkg::ST_READ;
          end else begin
            out_valid_d = 1'b1;
          end
        end
      end
      idq_pkg::ST_READ: begin
        state_d     = idq_pkg::ST_IDLE;
        out_valid_d = 1'b1;
      end
      default: begin
        state_d = idq_pkg::ST_IDLE;
      end
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= idq_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      front_q     <= '0;
      count_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        front_q <= front_d;
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      occ_q    <= count_d;
      status_q <= res_status;
      data_q   <= '0;
    end else if (state_q == idq_pkg::ST_READ) begin
      data_q <= mem_rdata_i;
    end
  end

  assign mem_ctl_o.wr_en = accept && wr_req;
  assign mem_ctl_o.rd_en = accept && rd_req;
  assign mem_addr_o      = addr;
  assign mem_wdata_o     = data_in_i;

  assign out_valid_o = out_valid_q;
  assign data_out_o  = data_q;
  assign occupancy_o = occ_q;
  assign status_o    = status_q;

endmodule

`default_nettype wire

[rtl/indexed_deque_core.sv]
// ---------------------------------------------------------------------------
// Indexed deque core
// Bounded double-ended queue of signed words held in a ring buffer.
// ---------------------------------------------------------------------------
// The core holds up to DEPTH signed 32-bit words and takes one transaction at
// a time: push front, push back, pop front, pop back, or read at a position
// counted from the front. A push, a failed operation or an unused code
// delivers its result in the cycle after acceptance; a pop or a read first
// passes through a read state, as the element memory has a single port with
// a registered read. The next transaction is accepted in the cycle a pending
// result is taken. Entries that were never written hold no defined value, so
// no clearing pass follows reset and the core is ready at once.
`default_nettype none

module indexed_deque_core #(
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned PtrW = $clog2(DEPTH),
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic        [idq_pkg::FUNC_W-1:0]   func_i,
  input  wire logic signed [idq_pkg::DATA_W-1:0]   data_in_i,
  input  wire logic        [PtrW-1:0]              position_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed      [idq_pkg::DATA_W-1:0]   data_out_o,
  output logic             [CntW-1:0]              occupancy_o,
  output logic             [idq_pkg::STAT_W-1:0]   status_o
);

  idq_pkg::mem_ctl_t          mem_ctl;
  logic [PtrW-1:0]            mem_addr;
  logic [idq_pkg::DATA_W-1:0] mem_wdata;
  logic [idq_pkg::DATA_W-1:0] mem_rdata;

  idq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .data_in_i   (data_in_i),
    .position_i  (position_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_out_o  (data_out_o),
    .occupancy_o (occupancy_o),
    .status_o    (status_o),
    .mem_ctl_o   (mem_ctl),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  idq_mem #(
    .DEPTH(DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

endmodule

`default_nettype wire

[rtl/idq_checker.sv]
// ---------------------------------------------------------------------------
// Indexed deque checker
// Port-level checks on results and flow control, bound to the core.
// ---------------------------------------------------------------------------
`default_nettype none

`include "indexed_deque_core_defines.svh"

module idq_checker #(
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned PtrW = $clog2(DEPTH),
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                in_valid_i,
  input wire logic                                in_ready_o,
  input wire logic        [idq_pkg::FUNC_W-1:0]   func_i,
  input wire logic signed [idq_pkg::DATA_W-1:0]   data_in_i,
  input wire logic        [PtrW-1:0]              position_i,
  input wire logic                                out_valid_o,
  input wire logic                                out_ready_i,
  input wire logic signed [idq_pkg::DATA_W-1:0]   data_out_o,
  input wire logic        [CntW-1:0]              occupancy_o,
  input wire logic        [idq_pkg::STAT_W-1:0]   status_o
);

  logic stalled;
  logic in_seen;

  assign stalled = out_valid_o && !out_ready_i;
  assign in_seen = in_valid_i && (func_i == func_i) && (data_in_i == data_in_i)
                   && (position_i == position_i);

  // A full queue can only report full at the capacity.
  `IDQ_ASSERT_SAME(a_full_at_capacity, clk_i, rst_ni,
    out_valid_o && (status_o == idq_pkg::STATUS_FULL), occupancy_o == CntW'(DEPTH))

  // An empty error is only reported with nothing held.
  `IDQ_ASSERT_SAME(a_empty_at_zero, clk_i, rst_ni,
    out_valid_o && (status_o == idq_pkg::STATUS_EMPTY), occupancy_o == '0)

  // Failed operations return a zero value.
  `IDQ_ASSERT_SAME(a_error_zero_data, clk_i, rst_ni,
    out_valid_o && (status_o != idq_pkg::STATUS_OK), data_out_o == '0)

  // No new transaction is taken while a result waits.
  `IDQ_ASSERT_SAME(a_no_accept_when_stalled, clk_i, rst_ni,
    stalled && in_seen, !in_ready_o)

  // A stalled result holds its payload.
  `IDQ_ASSERT_NEXT(a_result_held, clk_i, rst_ni, stalled,
    out_valid_o && $stable(data_out_o) && $stable(occupancy_o) && $stable(status_o))

endmodule

bind indexed_deque_core idq_checker #(
  .DEPTH(DEPTH)
) u_idq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .func_i      (func_i),
  .data_in_i   (data_in_i),
  .position_i  (position_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .data_out_o  (data_out_o),
  .occupancy_o (occupancy_o),
  .status_o    (status_o)
);

`default_nettype wire

[bench/tb_indexed_deque_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Indexed deque core testbench
// Sends push, pop, indexed read and spare-code transactions to the deque and
// predicts every result with a shadow ring buffer. Results are compared field
// by field in arrival order. Both handshakes idle at random, a long output
// stall fills the core, and the queue is driven from empty up to full.
// ----------------------------------------------------------------------------

module tb_indexed_deque_core;

  localparam int unsigned DEPTH = 1024;
  localparam int unsigned PTR_W = 10;
  localparam int unsigned CNT_W = 11;
  localparam logic [idq_pkg::FUNC_W-1:0] FUNC_SPARE_FIRST = 3'd5;
  localparam logic [idq_pkg::FUNC_W-1:0] FUNC_SPARE_MID = 3'd6;
  localparam logic [idq_pkg::FUNC_W-1:0] FUNC_SPARE_LAST = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef struct {
    logic signed [idq_pkg::DATA_W-1:0] data;
    logic [CNT_W-1:0] occupancy;
    idq_pkg::status_e status;
  } deque_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [idq_pkg::FUNC_W-1:0] func_i = '0;
  logic signed [idq_pkg::DATA_W-1:0] data_in_i = '0;
  logic [PTR_W-1:0] position_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [idq_pkg::DATA_W-1:0] data_out_o;
  logic [CNT_W-1:0] occupancy_o;
  logic [idq_pkg::STAT_W-1:0] status_o;

  logic signed [idq_pkg::DATA_W-1:0] shadow_store [DEPTH];
  logic [PTR_W-1:0] shadow_front = '0;
  int unsigned shadow_count = 0;
  deque_result_t pending_results [$];

  int unsigned error_count = 0;
  int unsigned sent_count = 0;
  int unsigned status_tally [4] = '{default: 0};
  int unsigned cycle_count = 0;
  int unsigned calm_sends = 0;
  int unsigned long_hold = 0;
  int unsigned stall_cycles = 0;
  int unsigned calm_cycles = 0;
  bit quiet = 1'b0;

  indexed_deque_core #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (func_i),
    .data_in_i  (data_in_i),
    .position_i (position_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .data_out_o (data_out_o),
    .occupancy_o(occupancy_o),
    .status_o   (status_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("indexed_deque_core test failed");
      $finish;
    end
  end

  function automatic deque_result_t deque_apply(input logic [idq_pkg::FUNC_W-1:0] f,
                                                input logic signed [idq_pkg::DATA_W-1:0] d,
                                                input logic [PTR_W-1:0] p);
    deque_result_t r;
    logic [PTR_W-1:0] slot;
    r.data = '0;
    r.status = idq_pkg::STATUS_OK;
    case (f)
      idq_pkg::FUNC_PUSH_FRONT, idq_pkg::FUNC_PUSH_BACK: begin
        if (shadow_count == DEPTH) begin
          r.status = idq_pkg::STATUS_FULL;
        end else begin
          if (f == idq_pkg::FUNC_PUSH_FRONT) begin
            shadow_front = shadow_front - 1'b1;
            slot = shadow_front;
          end else begin
            slot = shadow_front + PTR_W'(shadow_count);
          end
          shadow_store[slot] = d;
          shadow_count++;
        end
      end
      idq_pkg::FUNC_POP_FRONT, idq_pkg::FUNC_POP_BACK: begin
        if (shadow_count == 0) begin
          r.status = idq_pkg::STATUS_EMPTY;
        end else begin
          if (f == idq_pkg::FUNC_POP_FRONT) begin
            r.data = shadow_store[shadow_front];
            shadow_front = shadow_front + 1'b1;
          end else begin
            slot = shadow_front + PTR_W'(shadow_count - 1);
            r.data = shadow_store[slot];
          end
          shadow_count--;
        end
      end
      idq_pkg::FUNC_READ: begin
        if (int'(p) >= shadow_count) begin
          r.status = idq_pkg::STATUS_RANGE;
        end else begin
          slot = shadow_front + p;
          r.data = shadow_store[slot];
        end
      end
      default: ;
    endcase
    r.occupancy = CNT_W'(shadow_count);
    return r;
  endfunction

  task automatic send_op(input logic [idq_pkg::FUNC_W-1:0] f,
                         input logic signed [idq_pkg::DATA_W-1:0] d,
                         input logic [PTR_W-1:0] p);
    if (!quiet && calm_sends == 0 && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
      calm_sends = $urandom_range(0, 30);
    end else if (calm_sends > 0) begin
      calm_sends--;
    end
    in_valid_i <= 1'b1;
    func_i <= f;
    data_in_i <= d;
    position_i <= p;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(deque_apply(f, d, p));
    sent_count++;
  endtask

  task automatic send_mixed(input int unsigned push_w, input int unsigned pop_w,
                            input int unsigned read_w, input int unsigned spare_w);
    int unsigned pick;
    logic [idq_pkg::FUNC_W-1:0] f;
    logic [PTR_W-1:0] p;
    pick = $urandom_range(0, push_w + pop_w + read_w + spare_w - 1);
    if (pick < push_w) begin
      f = $urandom_range(0, 1) ? idq_pkg::FUNC_PUSH_BACK : idq_pkg::FUNC_PUSH_FRONT;
    end else if (pick < push_w + pop_w) begin
      f = $urandom_range(0, 1) ? idq_pkg::FUNC_POP_BACK : idq_pkg::FUNC_POP_FRONT;
    end else if (pick < push_w + pop_w + read_w) begin
      f = idq_pkg::FUNC_READ;
    end else begin
      f = idq_pkg::FUNC_W'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST));
    end
    // Most reads land inside the held range so that stored values come back.
    if (shadow_count > 0 && $urandom_range(0, 3) != 0) begin
      p = PTR_W'($urandom_range(0, shadow_count - 1));
    end else begin
      p = PTR_W'($urandom);
    end
    send_op(f, $urandom, p);
  endtask

  task automatic wait_drained(input int unsigned settle);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : result_sink
    if (!quiet && long_hold == 0 && stall_cycles == 0) begin
      if (calm_cycles > 0) begin
        calm_cycles--;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_cycles = $urandom_range(1, 17);
      end
    end
    if (long_hold > 0) begin
      out_ready_i <= 1'b0;
      long_hold--;
    end else if (stall_cycles > 0) begin
      out_ready_i <= 1'b0;
      stall_cycles--;
      if (stall_cycles == 0) calm_cycles = $urandom_range(0, 60);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : result_check
    deque_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: data %0d occupancy %0d status %0d",
                 $time, data_out_o, occupancy_o, status_o);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        status_tally[want.status]++;
        if (data_out_o !== want.data) begin
          $display("%0t: data_out expected %0d actual %0d", $time, want.data, data_out_o);
          error_count++;
        end
        if (occupancy_o !== want.occupancy) begin
          $display("%0t: occupancy expected %0d actual %0d", $time, want.occupancy,
                   occupancy_o);
          error_count++;
        end
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
          error_count++;
        end
      end
    end
  end

  task automatic test_directed_edges();
    send_op(idq_pkg::FUNC_POP_FRONT, 32'sd5, '0);
    send_op(idq_pkg::FUNC_POP_BACK, -32'sd5, '1);
    send_op(idq_pkg::FUNC_READ, '0, '0);
    send_op(idq_pkg::FUNC_READ, '1, '1);
    send_op(idq_pkg::FUNC_PUSH_FRONT, 32'sh7fffffff, '1);
    send_op(idq_pkg::FUNC_PUSH_BACK, 32'sh80000000, '0);
    send_op(idq_pkg::FUNC_PUSH_FRONT, '0, '0);
    send_op(idq_pkg::FUNC_PUSH_BACK, -32'sd1, '0);
    send_op(idq_pkg::FUNC_READ, '0, 10'd0);
    send_op(idq_pkg::FUNC_READ, '0, 10'd3);
    send_op(idq_pkg::FUNC_READ, '0, 10'd4);
    send_op(idq_pkg::FUNC_READ, '0, '1);
    send_op(FUNC_SPARE_FIRST, $urandom, PTR_W'($urandom));
    send_op(FUNC_SPARE_MID, $urandom, PTR_W'($urandom));
    send_op(FUNC_SPARE_LAST, $urandom, PTR_W'($urandom));
    send_op(idq_pkg::FUNC_POP_BACK, '0, '0);
    send_op(idq_pkg::FUNC_POP_FRONT, '0, '0);
    send_op(idq_pkg::FUNC_POP_BACK, '0, '0);
    send_op(idq_pkg::FUNC_POP_FRONT, '0, '0);
    send_op(idq_pkg::FUNC_POP_FRONT, '0, '0);
    send_op(idq_pkg::FUNC_PUSH_BACK, 32'sh5a5aa5a5, '0);
    send_op(idq_pkg::FUNC_POP_BACK, '0, '0);
    send_op(idq_pkg::FUNC_POP_BACK, '0, '0);
  endtask

  task automatic test_low_occupancy();
    repeat (100) send_mixed(40, 40, 15, 5);
  endtask

  task automatic test_fill_to_full();
    while (shadow_count < DEPTH) send_mixed(90, 3, 7, 0);
    send_op(idq_pkg::FUNC_PUSH_FRONT, $urandom, PTR_W'($urandom));
    send_op(idq_pkg::FUNC_PUSH_BACK, $urandom, PTR_W'($urandom));
    send_op(idq_pkg::FUNC_READ, $urandom, '1);
    send_op(idq_pkg::FUNC_READ, $urandom, '0);
  endtask

  task automatic test_near_full();
    repeat (120) send_mixed(45, 35, 20, 0);
  endtask

  task automatic test_output_backpressure();
    long_hold = 300;
    calm_sends = 40;
    repeat (30) send_mixed(40, 40, 20, 0);
  endtask

  task automatic test_unthrottled();
    quiet = 1'b1;
    repeat (100) send_mixed(40, 40, 15, 5);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_edges();
    test_low_occupancy();
    test_fill_to_full();
    test_near_full();
    test_output_backpressure();
    test_unthrottled();
    wait_drained(SETTLE_CYCLES);
    $display("Covered %0d transactions at both ends of the ring, with wrap-round, a full",
             sent_count);
    $display("queue and a long output stall: %0d ok, %0d empty, %0d range, %0d full.",
             status_tally[idq_pkg::STATUS_OK], status_tally[idq_pkg::STATUS_EMPTY],
             status_tally[idq_pkg::STATUS_RANGE], status_tally[idq_pkg::STATUS_FULL]);
    if (error_count == 0) begin
      $display("indexed_deque_core test passed");
    end else begin
      $display("indexed_deque_core test failed");
    end
    $finish;
  end

endmodule
